@@ rtl/core/multilevel_feedback_job_scheduler_unit_defines.svh @@
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; define SYNTH to compile the assertions away.
`ifndef MULTILEVEL_FEEDBACK_JOB_SCHEDULER_UNIT_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_JOB_SCHEDULER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define MFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/mfs_pkg.sv @@
// Shared types, codes and defaults of the feedback job scheduler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package mfs_pkg;
    localparam int MAX_JOBS_DEF = 16;
    localparam int ID_WIDTH_DEF = 16;
    localparam int LVL_W        = 2;
    localparam int WAIT_W       = 8;
    localparam int CFG_W        = 8;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [1:0] FN_TICK = 2'd0;
    localparam logic [1:0] FN_ENQ  = 2'd1;
    localparam logic [1:0] FN_DEQ  = 2'd2;
    localparam logic [1:0] FN_FIN  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [1:0] REG_PROMOTE    = 2'd0;
    localparam logic [1:0] REG_SLICE_HIGH = 2'd1;
    localparam logic [1:0] REG_SLICE_MID  = 2'd2;
    localparam logic [1:0] REG_SLICE_LOW  = 2'd3;

    localparam logic [CFG_W-1:0] PROMOTE_RST    = 8'd5;
    localparam logic [CFG_W-1:0] SLICE_HIGH_RST = 8'd1;
    localparam logic [CFG_W-1:0] SLICE_MID_RST  = 8'd2;
    localparam logic [CFG_W-1:0] SLICE_LOW_RST  = 8'd5;

    localparam logic signed [8:0] SLICE_IDLE = -9'sd2;

    typedef struct packed {
        logic [CFG_W-1:0] promote_wait;
        logic [CFG_W-1:0] slice_high;
        logic [CFG_W-1:0] slice_mid;
        logic [CFG_W-1:0] slice_low;
    } t_cfg;
endpackage

@@ rtl/core/mfs_cfg_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on mfs_pkg.
`timescale 1ns / 1ps
module mfs_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mfs_pkg::ADDR_W-1:0] paddr,
    input  logic [mfs_pkg::DATA_W-1:0] pwdata,
    output logic [mfs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output mfs_pkg::t_cfg              o_cfg
);
    mfs_pkg::t_cfg r_cfg;
    logic [1:0] idx;

    assign idx    = paddr[mfs_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.promote_wait <= mfs_pkg::PROMOTE_RST;
            r_cfg.slice_high   <= mfs_pkg::SLICE_HIGH_RST;
            r_cfg.slice_mid    <= mfs_pkg::SLICE_MID_RST;
            r_cfg.slice_low    <= mfs_pkg::SLICE_LOW_RST;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                mfs_pkg::REG_PROMOTE:    r_cfg.promote_wait <= pwdata[mfs_pkg::CFG_W-1:0];
                mfs_pkg::REG_SLICE_HIGH: r_cfg.slice_high   <= pwdata[mfs_pkg::CFG_W-1:0];
                mfs_pkg::REG_SLICE_MID:  r_cfg.slice_mid    <= pwdata[mfs_pkg::CFG_W-1:0];
                mfs_pkg::REG_SLICE_LOW:  r_cfg.slice_low    <= pwdata[mfs_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            mfs_pkg::REG_PROMOTE:    prdata = mfs_pkg::DATA_W'(r_cfg.promote_wait);
            mfs_pkg::REG_SLICE_HIGH: prdata = mfs_pkg::DATA_W'(r_cfg.slice_high);
            mfs_pkg::REG_SLICE_MID:  prdata = mfs_pkg::DATA_W'(r_cfg.slice_mid);
            mfs_pkg::REG_SLICE_LOW:  prdata = mfs_pkg::DATA_W'(r_cfg.slice_low);
            default:                 prdata = '0;
        endcase
    end
endmodule

@@ rtl/core/mfs_slot_mem.sv @@
// Slot table storage: a record memory (id, level, wait) and a link memory.
// Both have one write port and one registered read port. Depends on mfs_pkg.
`timescale 1ns / 1ps
module mfs_slot_mem #(
    parameter int MAX_JOBS = mfs_pkg::MAX_JOBS_DEF,
    parameter int ID_WIDTH = mfs_pkg::ID_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic [$clog2(MAX_JOBS)-1:0]                   i_ra,
    input  logic                                          i_rec_we,
    input  logic [$clog2(MAX_JOBS)-1:0]                   i_rec_wa,
    input  logic [ID_WIDTH+mfs_pkg::LVL_W+mfs_pkg::WAIT_W-1:0] i_rec_wd,
    output logic [ID_WIDTH+mfs_pkg::LVL_W+mfs_pkg::WAIT_W-1:0] o_rec_rd,
    input  logic                                          i_link_we,
    input  logic [$clog2(MAX_JOBS)-1:0]                   i_link_wa,
    input  logic [$clog2(MAX_JOBS)-1:0]                   i_link_wd,
    output logic [$clog2(MAX_JOBS)-1:0]                   o_link_rd
);
    localparam int SW = $clog2(MAX_JOBS);
    localparam int RW = ID_WIDTH + mfs_pkg::LVL_W + mfs_pkg::WAIT_W;

    logic [RW-1:0] rec_mem  [MAX_JOBS];
    logic [SW-1:0] link_mem [MAX_JOBS];

    always_ff @(posedge i_clk) begin
        if (i_rec_we) begin
            rec_mem[i_rec_wa] <= i_rec_wd;
        end
        o_rec_rd <= rec_mem[i_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            link_mem[i_link_wa] <= i_link_wd;
        end
        o_link_rd <= link_mem[i_ra];
    end
endmodule

@@ rtl/core/mfs_ctrl.sv @@
// Scheduler sequencer: walks the linked queues in the slot memory for aging,
// enqueue, dequeue and slice end, and holds the result register. Depends on mfs_pkg.
`timescale 1ns / 1ps
module mfs_ctrl #(
    parameter int MAX_JOBS = mfs_pkg::MAX_JOBS_DEF,
    parameter int ID_WIDTH = mfs_pkg::ID_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mfs_pkg::t_cfg           i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_func,
    input  logic [1:0]              i_priority_req,
    input  logic [ID_WIDTH-1:0]     i_job_id,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_running_valid,
    output logic [ID_WIDTH-1:0]     o_running_job,
    output logic [1:0]              o_running_level,
    output logic                    o_started,
    output logic                    o_stopped_valid,
    output logic [ID_WIDTH-1:0]     o_stopped_job,
    output logic                    o_killed,
    output logic [ID_WIDTH-1:0]     o_new_job_id,
    output logic [1:0]              o_status,
    output logic [$clog2(MAX_JOBS)-1:0] o_ra,
    output logic                    o_rec_we,
    output logic [$clog2(MAX_JOBS)-1:0] o_rec_wa,
    output logic [ID_WIDTH+mfs_pkg::LVL_W+mfs_pkg::WAIT_W-1:0] o_rec_wd,
    input  logic [ID_WIDTH+mfs_pkg::LVL_W+mfs_pkg::WAIT_W-1:0] i_rec_rd,
    output logic                    o_link_we,
    output logic [$clog2(MAX_JOBS)-1:0] o_link_wa,
    output logic [$clog2(MAX_JOBS)-1:0] o_link_wd,
    input  logic [$clog2(MAX_JOBS)-1:0] i_link_rd
);
    localparam int SW = $clog2(MAX_JOBS);
    localparam int WW = mfs_pkg::WAIT_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_AGE_NEXT  = 4'd1;
    localparam logic [3:0] S_AGE_RD    = 4'd2;
    localparam logic [3:0] S_AGE_WB    = 4'd3;
    localparam logic [3:0] S_OP        = 4'd4;
    localparam logic [3:0] S_ENQ_SCAN  = 4'd5;
    localparam logic [3:0] S_ENQ_ALLOC = 4'd6;
    localparam logic [3:0] S_DQ_NEXT   = 4'd7;
    localparam logic [3:0] S_DQ_RD     = 4'd8;
    localparam logic [3:0] S_DQ_WB     = 4'd9;
    localparam logic [3:0] S_SLICE     = 4'd10;
    localparam logic [3:0] S_POP_RD    = 4'd11;
    localparam logic [3:0] S_POP_WB    = 4'd12;
    localparam logic [3:0] S_SW        = 4'd13;
    localparam logic [3:0] S_SW2       = 4'd14;
    localparam logic [3:0] S_DONE      = 4'd15;

    // Control state (reset).
    logic [3:0]          r_state, n_state;
    logic [MAX_JOBS-1:0] r_used, n_used;
    logic [2:0]          r_hvld, n_hvld;
    logic                r_run_vld, n_run_vld;
    logic                r_run_done, n_run_done;
    logic [1:0]          r_run_level, n_run_level;
    logic signed [8:0]   r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic [ID_WIDTH-1:0] r_idc, n_idc;
    logic                r_ovld, n_ovld;

    // Working and payload registers.
    logic [SW-1:0]       r_head [3];
    logic [SW-1:0]       n_head [3];
    logic [SW-1:0]       r_tail [3];
    logic [SW-1:0]       n_tail [3];
    logic [1:0]          r_func, n_func;
    logic [1:0]          r_lvl, n_lvl;
    logic [ID_WIDTH-1:0] r_jid, n_jid;
    logic [SW-1:0]       r_cur, n_cur;
    logic [1:0]          r_q, n_q;
    logic                r_kany, n_kany;
    logic [SW-1:0]       r_khead, n_khead;
    logic [SW-1:0]       r_ktail, n_ktail;
    logic                r_prev_any, n_prev_any;
    logic [SW-1:0]       r_prev, n_prev;
    logic [SW-1:0]       r_scan, n_scan;
    logic [SW-1:0]       r_run_slot, n_run_slot;
    logic [ID_WIDTH-1:0] r_run_id, n_run_id;
    logic [1:0]          r_run_slvl, n_run_slvl;
    logic [SW-1:0]       r_nxt, n_nxt;
    logic [ID_WIDTH-1:0] r_nxt_id, n_nxt_id;
    logic [1:0]          r_nxt_lvl, n_nxt_lvl;
    logic                r_from_slice, n_from_slice;
    logic                r_started, n_started;
    logic                r_stopped, n_stopped;
    logic [ID_WIDTH-1:0] r_stop_id, n_stop_id;
    logic                r_killed, n_killed;
    logic [ID_WIDTH-1:0] r_new_id, n_new_id;
    logic [1:0]          r_status, n_status;
    logic                r_o_rv, n_o_rv;
    logic [ID_WIDTH-1:0] r_o_rj, n_o_rj;
    logic [1:0]          r_o_rl, n_o_rl;
    logic                r_o_st, n_o_st;
    logic                r_o_sv, n_o_sv;
    logic [ID_WIDTH-1:0] r_o_sj, n_o_sj;
    logic                r_o_k, n_o_k;
    logic [ID_WIDTH-1:0] r_o_nid, n_o_nid;
    logic [1:0]          r_o_stat, n_o_stat;

    logic [ID_WIDTH-1:0] rd_id;
    logic [1:0]          rd_lvl;
    logic [WW-1:0]       rd_wait;

    assign rd_id   = i_rec_rd[ID_WIDTH+mfs_pkg::LVL_W+WW-1 -: ID_WIDTH];
    assign rd_lvl  = i_rec_rd[WW+mfs_pkg::LVL_W-1 -: mfs_pkg::LVL_W];
    assign rd_wait = i_rec_rd[WW-1:0];

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_ovld;
    assign o_running_valid = r_o_rv;
    assign o_running_job   = r_o_rj;
    assign o_running_level = r_o_rl;
    assign o_started       = r_o_st;
    assign o_stopped_valid = r_o_sv;
    assign o_stopped_job   = r_o_sj;
    assign o_killed        = r_o_k;
    assign o_new_job_id    = r_o_nid;
    assign o_status        = r_o_stat;
    assign o_ra            = r_cur;

    always_comb begin
        logic [WW-1:0]       w_inc;
        logic                k_any;
        logic [SW-1:0]       k_head;
        logic [SW-1:0]       k_tail;
        logic                do_push;
        logic [1:0]          pq;
        logic [SW-1:0]       ps;
        logic signed [8:0]   cnt_inc;
        logic [7:0]          lim;
        logic                lim_ok;
        logic [ID_WIDTH-1:0] id_next;
        logic [1:0]          dlv;

        n_state = r_state;   n_used = r_used;   n_hvld = r_hvld;
        n_run_vld = r_run_vld;  n_run_done = r_run_done;  n_run_level = r_run_level;
        n_cnt = r_cnt;  n_busy = r_busy;  n_idc = r_idc;
        n_ovld = r_ovld && !i_ready;
        n_head = r_head;  n_tail = r_tail;
        n_func = r_func;  n_lvl = r_lvl;  n_jid = r_jid;
        n_cur = r_cur;  n_q = r_q;
        n_kany = r_kany;  n_khead = r_khead;  n_ktail = r_ktail;
        n_prev_any = r_prev_any;  n_prev = r_prev;  n_scan = r_scan;
        n_run_slot = r_run_slot;  n_run_id = r_run_id;  n_run_slvl = r_run_slvl;
        n_nxt = r_nxt;  n_nxt_id = r_nxt_id;  n_nxt_lvl = r_nxt_lvl;
        n_from_slice = r_from_slice;
        n_started = r_started;  n_stopped = r_stopped;  n_stop_id = r_stop_id;
        n_killed = r_killed;  n_new_id = r_new_id;  n_status = r_status;
        n_o_rv = r_o_rv;  n_o_rj = r_o_rj;  n_o_rl = r_o_rl;  n_o_st = r_o_st;
        n_o_sv = r_o_sv;  n_o_sj = r_o_sj;  n_o_k = r_o_k;  n_o_nid = r_o_nid;
        n_o_stat = r_o_stat;

        o_rec_we = 1'b0;  o_rec_wa = r_cur;  o_rec_wd = i_rec_rd;
        o_link_we = 1'b0;  o_link_wa = r_ktail;  o_link_wd = r_cur;

        w_inc   = (rd_wait == {WW{1'b1}}) ? rd_wait : rd_wait + 1'b1;
        k_any   = r_kany;
        k_head  = r_khead;
        k_tail  = r_ktail;
        do_push = 1'b0;
        pq      = 2'd0;
        ps      = r_cur;
        cnt_inc = ((r_cnt >= -9'sd1) && (r_cnt < 9'sd255)) ? r_cnt + 9'sd1 : r_cnt;
        lim     = i_cfg.slice_low;
        lim_ok  = 1'b1;
        id_next = r_idc + 1'b1;
        if (id_next == '0) begin
            id_next = {{(ID_WIDTH-1){1'b0}}, 1'b1};
        end
        dlv = (r_run_slvl == 2'd3) ? 2'd2 : 2'd1;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func    = i_func;
                    n_lvl     = (i_priority_req == 2'd0) ? 2'd1 : i_priority_req;
                    n_jid     = i_job_id;
                    n_started = 1'b0;  n_stopped = 1'b0;  n_stop_id = '0;
                    n_killed  = 1'b0;  n_new_id = '0;  n_status = mfs_pkg::ST_OK;
                    if (i_func == mfs_pkg::FN_FIN) begin
                        if (r_run_vld) begin
                            n_run_done = 1'b1;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_q     = 2'd2;
                        n_state = S_AGE_NEXT;
                    end
                end
            end
            S_AGE_NEXT: begin
                if (r_hvld[r_q]) begin
                    n_cur   = r_head[r_q];
                    n_kany  = 1'b0;
                    n_state = S_AGE_RD;
                end else if (r_q == 2'd0) begin
                    n_state = S_OP;
                end else begin
                    n_q = r_q - 2'd1;
                end
            end
            S_AGE_RD: n_state = S_AGE_WB;
            S_AGE_WB: begin
                o_rec_we = 1'b1;
                o_rec_wd = {rd_id, rd_lvl, w_inc};
                if (r_q != 2'd2) begin
                    if (w_inc >= i_cfg.promote_wait) begin
                        // Promoted to the tail of the next level up.
                        o_rec_wd = {rd_id, r_q + 2'd2, {WW{1'b0}}};
                        do_push  = 1'b1;
                        pq       = r_q + 2'd1;
                    end else begin
                        if (r_kany) begin
                            o_link_we = 1'b1;
                            o_link_wa = r_ktail;
                            o_link_wd = r_cur;
                        end else begin
                            k_head = r_cur;
                        end
                        k_any  = 1'b1;
                        k_tail = r_cur;
                    end
                end
                n_kany = k_any;  n_khead = k_head;  n_ktail = k_tail;
                if (r_cur == r_tail[r_q]) begin
                    if (r_q != 2'd2) begin
                        n_hvld[r_q] = k_any;
                        n_head[r_q] = k_head;
                        n_tail[r_q] = k_tail;
                    end
                    if (r_q == 2'd0) begin
                        n_state = S_OP;
                    end else begin
                        n_q     = r_q - 2'd1;
                        n_state = S_AGE_NEXT;
                    end
                end else begin
                    n_cur   = i_link_rd;
                    n_state = S_AGE_RD;
                end
            end
            S_OP: begin
                case (r_func)
                    mfs_pkg::FN_ENQ: begin
                        n_scan  = '0;
                        n_state = S_ENQ_SCAN;
                    end
                    mfs_pkg::FN_DEQ: begin
                        if (r_run_vld && r_run_id == r_jid) begin
                            n_used[r_run_slot] = 1'b0;
                            n_run_vld  = 1'b0;
                            n_run_done = 1'b0;
                            n_killed   = 1'b1;
                            n_state    = S_SLICE;
                        end else begin
                            n_q     = 2'd2;
                            n_state = S_DQ_NEXT;
                        end
                    end
                    default: n_state = S_SLICE;
                endcase
            end
            S_ENQ_SCAN: begin
                if (!r_used[r_scan]) begin
                    n_nxt   = r_scan;
                    n_state = S_ENQ_ALLOC;
                end else if (r_scan == SW'(MAX_JOBS - 1)) begin
                    n_status = mfs_pkg::ST_FULL;
                    n_state  = S_SLICE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_ENQ_ALLOC: begin
                n_idc           = id_next;
                n_new_id        = id_next;
                n_used[r_nxt]   = 1'b1;
                o_rec_we        = 1'b1;
                o_rec_wa        = r_nxt;
                o_rec_wd        = {id_next, r_lvl, {WW{1'b0}}};
                if (r_lvl > r_run_level) begin
                    // Preempts: the new job never enters its queue.
                    n_nxt_id     = id_next;
                    n_nxt_lvl    = r_lvl;
                    n_from_slice = 1'b0;
                    n_state      = S_SW;
                end else begin
                    do_push = 1'b1;
                    pq      = r_lvl - 2'd1;
                    ps      = r_nxt;
                    n_state = S_SLICE;
                end
            end
            S_DQ_NEXT: begin
                if (r_hvld[r_q]) begin
                    n_cur      = r_head[r_q];
                    n_prev_any = 1'b0;
                    n_state    = S_DQ_RD;
                end else if (r_q == 2'd0) begin
                    n_status = mfs_pkg::ST_NOT_FOUND;
                    n_state  = S_SLICE;
                end else begin
                    n_q = r_q - 2'd1;
                end
            end
            S_DQ_RD: n_state = S_DQ_WB;
            S_DQ_WB: begin
                if (rd_id == r_jid) begin
                    n_used[r_cur] = 1'b0;
                    if (!r_prev_any) begin
                        if (r_cur == r_tail[r_q]) begin
                            n_hvld[r_q] = 1'b0;
                        end else begin
                            n_head[r_q] = i_link_rd;
                        end
                    end else begin
                        o_link_we = 1'b1;
                        o_link_wa = r_prev;
                        o_link_wd = i_link_rd;
                        if (r_cur == r_tail[r_q]) begin
                            n_tail[r_q] = r_prev;
                        end
                    end
                    n_state = S_SLICE;
                end else if (r_cur == r_tail[r_q]) begin
                    if (r_q == 2'd0) begin
                        n_status = mfs_pkg::ST_NOT_FOUND;
                        n_state  = S_SLICE;
                    end else begin
                        n_q     = r_q - 2'd1;
                        n_state = S_DQ_NEXT;
                    end
                end else begin
                    n_prev_any = 1'b1;
                    n_prev     = r_cur;
                    n_cur      = i_link_rd;
                    n_state    = S_DQ_RD;
                end
            end
            S_SLICE: begin
                n_cnt   = cnt_inc;
                n_state = S_DONE;
                case (r_run_level)
                    2'd3:    lim = i_cfg.slice_high;
                    2'd2:    lim = i_cfg.slice_mid;
                    2'd1:    lim = i_cfg.slice_low;
                    default: lim_ok = 1'b0;
                endcase
                if (r_busy && cnt_inc > 9'sd0 && lim_ok && cnt_inc[7:0] >= lim) begin
                    if (r_hvld != 3'b000) begin
                        n_q          = r_hvld[2] ? 2'd2 : (r_hvld[1] ? 2'd1 : 2'd0);
                        n_cur        = r_head[n_q];
                        n_from_slice = 1'b1;
                        n_state      = S_POP_RD;
                    end else if (r_run_vld && !r_run_done) begin
                        // Nothing waiting: the running job starts a fresh slice.
                        n_cnt = 9'sd0;
                    end else begin
                        if (r_run_vld) begin
                            n_used[r_run_slot] = 1'b0;
                        end
                        n_run_vld   = 1'b0;
                        n_run_done  = 1'b0;
                        n_cnt       = mfs_pkg::SLICE_IDLE;
                        n_busy      = 1'b0;
                        n_run_level = 2'd0;
                    end
                end
            end
            S_POP_RD: n_state = S_POP_WB;
            S_POP_WB: begin
                if (r_cur == r_tail[r_q]) begin
                    n_hvld[r_q] = 1'b0;
                end else begin
                    n_head[r_q] = i_link_rd;
                end
                n_nxt     = r_cur;
                n_nxt_id  = rd_id;
                n_nxt_lvl = rd_lvl;
                n_state   = S_SW;
            end
            S_SW: begin
                n_cnt  = -9'sd1;
                n_busy = 1'b1;
                if (r_run_vld && r_run_done) begin
                    n_used[r_run_slot] = 1'b0;
                end else if (r_run_vld) begin
                    // The paused job drops one level, no lower than level 1, and waits afresh.
                    n_stopped = 1'b1;
                    n_stop_id = r_run_id;
                    o_rec_we  = 1'b1;
                    o_rec_wa  = r_run_slot;
                    o_rec_wd  = {r_run_id, dlv, {WW{1'b0}}};
                    do_push   = 1'b1;
                    pq        = dlv - 2'd1;
                    ps        = r_run_slot;
                end
                n_state = S_SW2;
            end
            S_SW2: begin
                o_rec_we    = 1'b1;
                o_rec_wa    = r_nxt;
                o_rec_wd    = {r_nxt_id, r_nxt_lvl, {WW{1'b0}}};
                n_run_slot  = r_nxt;
                n_run_vld   = 1'b1;
                n_run_done  = 1'b0;
                n_run_id    = r_nxt_id;
                n_run_slvl  = r_nxt_lvl;
                n_run_level = r_nxt_lvl;
                n_started   = 1'b1;
                n_state     = r_from_slice ? S_DONE : S_SLICE;
            end
            S_DONE: begin
                if (!r_ovld || i_ready) begin
                    n_ovld   = 1'b1;
                    n_o_rv   = r_run_vld;
                    n_o_rj   = r_run_vld ? r_run_id : '0;
                    n_o_rl   = r_run_level;
                    n_o_st   = r_started;
                    n_o_sv   = r_stopped;
                    n_o_sj   = r_stop_id;
                    n_o_k    = r_killed;
                    n_o_nid  = r_new_id;
                    n_o_stat = r_status;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (do_push) begin
            if (r_hvld[pq]) begin
                o_link_we = 1'b1;
                o_link_wa = r_tail[pq];
                o_link_wd = ps;
            end else begin
                n_hvld[pq] = 1'b1;
                n_head[pq] = ps;
            end
            n_tail[pq] = ps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_hvld      <= '0;
            r_run_vld   <= 1'b0;
            r_run_done  <= 1'b0;
            r_run_level <= 2'd0;
            r_cnt       <= mfs_pkg::SLICE_IDLE;
            r_busy      <= 1'b0;
            r_idc       <= '0;
            r_ovld      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_hvld      <= n_hvld;
            r_run_vld   <= n_run_vld;
            r_run_done  <= n_run_done;
            r_run_level <= n_run_level;
            r_cnt       <= n_cnt;
            r_busy      <= n_busy;
            r_idc       <= n_idc;
            r_ovld      <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;  r_tail <= n_tail;
        r_func <= n_func;  r_lvl <= n_lvl;  r_jid <= n_jid;
        r_cur <= n_cur;  r_q <= n_q;
        r_kany <= n_kany;  r_khead <= n_khead;  r_ktail <= n_ktail;
        r_prev_any <= n_prev_any;  r_prev <= n_prev;  r_scan <= n_scan;
        r_run_slot <= n_run_slot;  r_run_id <= n_run_id;  r_run_slvl <= n_run_slvl;
        r_nxt <= n_nxt;  r_nxt_id <= n_nxt_id;  r_nxt_lvl <= n_nxt_lvl;
        r_from_slice <= n_from_slice;
        r_started <= n_started;  r_stopped <= n_stopped;  r_stop_id <= n_stop_id;
        r_killed <= n_killed;  r_new_id <= n_new_id;  r_status <= n_status;
        r_o_rv <= n_o_rv;  r_o_rj <= n_o_rj;  r_o_rl <= n_o_rl;  r_o_st <= n_o_st;
        r_o_sv <= n_o_sv;  r_o_sj <= n_o_sj;  r_o_k <= n_o_k;  r_o_nid <= n_o_nid;
        r_o_stat <= n_o_stat;
    end
endmodule

@@ rtl/core/multilevel_feedback_job_scheduler_unit.sv @@
// Top level of the three-level feedback job scheduler.
// Depends on mfs_pkg, mfs_cfg_regs, mfs_slot_mem, mfs_ctrl and the defines header.
//
//  Port group   Direction  Handshake         Payload
//  input item   in         i_valid/o_ready   i_func, i_priority_req, i_job_id
//  result item  out        o_valid/i_ready   o_running_* .. o_status
//  config       in/out     psel/penable      paddr, pwdata, prdata (pready tied high)
//
// One item is worked on at a time. A finish item goes straight to the result; any
// other item first ages every queued job, then does an enqueue slot search or a
// dequeue search where it asks for one, and then the slice check with a possible
// switch. Each visited job takes a read state and a writeback state, as the slot memory read is registered.
// Reset is synchronous and needs no clearing pass. A result waiting in the output
// register does not block the next item; only the final handoff waits for it.
`timescale 1ns / 1ps
`include "multilevel_feedback_job_scheduler_unit_defines.svh"
module multilevel_feedback_job_scheduler_unit #(
    parameter int MAX_JOBS = mfs_pkg::MAX_JOBS_DEF,
    parameter int ID_WIDTH = mfs_pkg::ID_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_func,
    input  logic [1:0]                 i_priority_req,
    input  logic [ID_WIDTH-1:0]        i_job_id,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_running_valid,
    output logic [ID_WIDTH-1:0]        o_running_job,
    output logic [1:0]                 o_running_level,
    output logic                       o_started,
    output logic                       o_stopped_valid,
    output logic [ID_WIDTH-1:0]        o_stopped_job,
    output logic                       o_killed,
    output logic [ID_WIDTH-1:0]        o_new_job_id,
    output logic [1:0]                 o_status,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mfs_pkg::ADDR_W-1:0] paddr,
    input  logic [mfs_pkg::DATA_W-1:0] pwdata,
    output logic [mfs_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    localparam int SW = $clog2(MAX_JOBS);
    localparam int RW = ID_WIDTH + mfs_pkg::LVL_W + mfs_pkg::WAIT_W;

    mfs_pkg::t_cfg cfg;
    logic [SW-1:0] ra;
    logic          rec_we;
    logic [SW-1:0] rec_wa;
    logic [RW-1:0] rec_wd;
    logic [RW-1:0] rec_rd;
    logic          link_we;
    logic [SW-1:0] link_wa;
    logic [SW-1:0] link_wd;
    logic [SW-1:0] link_rd;

    mfs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mfs_slot_mem #(.MAX_JOBS(MAX_JOBS), .ID_WIDTH(ID_WIDTH)) u_mem (
        .i_clk     (i_clk),
        .i_ra      (ra),
        .i_rec_we  (rec_we),
        .i_rec_wa  (rec_wa),
        .i_rec_wd  (rec_wd),
        .o_rec_rd  (rec_rd),
        .i_link_we (link_we),
        .i_link_wa (link_wa),
        .i_link_wd (link_wd),
        .o_link_rd (link_rd)
    );

    mfs_ctrl #(.MAX_JOBS(MAX_JOBS), .ID_WIDTH(ID_WIDTH)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_priority_req  (i_priority_req),
        .i_job_id        (i_job_id),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_running_valid (o_running_valid),
        .o_running_job   (o_running_job),
        .o_running_level (o_running_level),
        .o_started       (o_started),
        .o_stopped_valid (o_stopped_valid),
        .o_stopped_job   (o_stopped_job),
        .o_killed        (o_killed),
        .o_new_job_id    (o_new_job_id),
        .o_status        (o_status),
        .o_ra            (ra),
        .o_rec_we        (rec_we),
        .o_rec_wa        (rec_wa),
        .o_rec_wd        (rec_wd),
        .i_rec_rd        (rec_rd),
        .o_link_we       (link_we),
        .o_link_wa       (link_wa),
        .o_link_wd       (link_wd),
        .i_link_rd       (link_rd)
    );

    // An accepted item always makes the block busy, so o_ready drops once the item is taken.
    `MFS_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready, "ready right after accept")
    // A job that was started in a step is still running at the end of it.
    `MFS_ASSERT(a_started_runs, i_clk, i_rst_n, o_valid && o_started |-> o_running_valid, "started but idle")
    // A failed request never hands out an identifier.
    `MFS_ASSERT(a_fail_no_id, i_clk, i_rst_n, o_valid && o_status != mfs_pkg::ST_OK |-> o_new_job_id == '0, "id on failed request")
    // An idle processor reports no running job.
    `MFS_ASSERT(a_idle_zero, i_clk, i_rst_n, o_valid && !o_running_valid |-> o_running_job == '0, "job id while idle")
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the three-level feedback job scheduler.
// Depends on mfs_pkg and multilevel_feedback_job_scheduler_unit; a built-in predictor
// tracks slots, queues and the running job and checks every result item.
`timescale 1ns / 1ps
module tb_top;
    import mfs_pkg::*;

    localparam int NSLOT = 16;
    localparam int NO_SLOT = NSLOT;

    typedef struct packed {
        logic        running_valid;
        logic [15:0] running_job;
        logic [1:0]  running_level;
        logic        started;
        logic        stopped_valid;
        logic [15:0] stopped_job;
        logic        killed;
        logic [15:0] new_job_id;
        logic [1:0]  status;
    } t_sched_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func = FN_TICK;
    logic [1:0]  i_priority_req = 2'd1;
    logic [15:0] i_job_id = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_sched_out  got;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    multilevel_feedback_job_scheduler_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_priority_req(i_priority_req), .i_job_id(i_job_id),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_running_valid(got.running_valid), .o_running_job(got.running_job),
        .o_running_level(got.running_level), .o_started(got.started),
        .o_stopped_valid(got.stopped_valid), .o_stopped_job(got.stopped_job),
        .o_killed(got.killed), .o_new_job_id(got.new_job_id), .o_status(got.status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // Scheduler state as predicted from the accepted items.
    logic [15:0] slot_id    [NSLOT];
    logic [1:0]  slot_lvl   [NSLOT];
    logic [7:0]  slot_wait  [NSLOT];
    logic        slot_used  [NSLOT];
    int          slot_next  [NSLOT];
    int          q_head [3];
    int          q_tail [3];
    int          run_slot;
    logic        run_done;
    logic [1:0]  run_lvl;
    int          slice_cnt;
    logic        busy;
    logic [15:0] id_ctr;
    logic [7:0]  cfg_promote, cfg_high, cfg_mid, cfg_low;
    int          walk [NSLOT];
    int          keep [NSLOT];
    logic        ev_started, ev_stopped;
    logic [15:0] ev_stopped_job;

    t_sched_out  pending_results [$];
    int          err_count = 0;
    int          snd_idle_pct = 0;
    int          rcv_stall_pct = 0;

    function automatic int q_load(int q);
        int n;
        int s;
        n = 0;
        s = q_head[q];
        while (s < NSLOT && n < NSLOT) begin
            walk[n] = s;
            n++;
            if (s == q_tail[q]) break;
            s = slot_next[s];
        end
        return n;
    endfunction

    function automatic void q_store(int q, int n);
        if (n == 0) begin
            q_head[q] = NO_SLOT;
            return;
        end
        q_head[q] = keep[0];
        for (int i = 0; i + 1 < n; i++) slot_next[keep[i]] = keep[i + 1];
        q_tail[q] = keep[n - 1];
        slot_next[keep[n - 1]] = NO_SLOT;
    endfunction

    function automatic void q_push(int q, int s);
        if (q_head[q] >= NSLOT) q_head[q] = s;
        else slot_next[q_tail[q]] = s;
        q_tail[q] = s;
        slot_next[s] = NO_SLOT;
    endfunction

    function automatic int q_pop(int q);
        int s;
        s = q_head[q];
        if (s >= NSLOT) return NO_SLOT;
        if (s == q_tail[q]) q_head[q] = NO_SLOT;
        else q_head[q] = slot_next[s];
        return s;
    endfunction

    function automatic void bump_wait(int s);
        if (slot_wait[s] != 8'hFF) slot_wait[s]++;
    endfunction

    function automatic void age_waiting();
        int n;
        int k;
        n = q_load(2);
        for (int i = 0; i < n; i++) bump_wait(walk[i]);
        for (int q = 1; q >= 0; q--) begin
            n = q_load(q);
            k = 0;
            for (int i = 0; i < n; i++) begin
                bump_wait(walk[i]);
                if (slot_wait[walk[i]] >= cfg_promote) begin
                    slot_lvl[walk[i]] = 2'(q + 2);
                    slot_wait[walk[i]] = '0;
                    q_push(q + 1, walk[i]);
                end else begin
                    keep[k] = walk[i];
                    k++;
                end
            end
            q_store(q, k);
        end
    endfunction

    function automatic void switch_job(int nxt);
        int lv;
        if (nxt != NO_SLOT) begin
            slice_cnt = -1;
            busy = 1'b1;
        end
        if (run_slot != NO_SLOT && run_done) begin
            slot_used[run_slot] = 1'b0;
            run_slot = NO_SLOT;
            run_done = 1'b0;
        end
        if (nxt == NO_SLOT) begin
            if (run_slot == NO_SLOT) begin
                slice_cnt = -2;
                busy = 1'b0;
                run_lvl = '0;
            end
            return;
        end
        if (run_slot != NO_SLOT) begin
            lv = (slot_lvl[run_slot] == 2'd3) ? 2 : 1;
            ev_stopped = 1'b1;
            ev_stopped_job = slot_id[run_slot];
            slot_lvl[run_slot] = 2'(lv);
            slot_wait[run_slot] = '0;
            q_push(lv - 1, run_slot);
        end
        run_slot = nxt;
        run_done = 1'b0;
        slot_wait[nxt] = '0;
        run_lvl = slot_lvl[nxt];
        ev_started = 1'b1;
    endfunction

    function automatic logic [15:0] enqueue_job(int lvl, inout logic [1:0] st);
        int s;
        int n;
        int k;
        s = 0;
        while (s < NSLOT && slot_used[s]) s++;
        if (s >= NSLOT) begin
            st = ST_FULL;
            return '0;
        end
        id_ctr = id_ctr + 16'd1;
        if (id_ctr == '0) id_ctr = 16'd1;
        slot_used[s] = 1'b1;
        slot_id[s] = id_ctr;
        slot_lvl[s] = 2'(lvl);
        slot_wait[s] = '0;
        q_push(lvl - 1, s);
        if (lvl > run_lvl) begin
            n = q_load(lvl - 1);
            k = 0;
            for (int i = 0; i < n; i++) begin
                if (walk[i] != s) begin
                    keep[k] = walk[i];
                    k++;
                end
            end
            q_store(lvl - 1, k);
            switch_job(s);
        end
        return id_ctr;
    endfunction

    function automatic void dequeue_job(logic [15:0] jid, inout logic kill,
                                        inout logic [1:0] st);
        int n;
        int k;
        logic hit;
        if (run_slot != NO_SLOT && slot_id[run_slot] == jid) begin
            slot_used[run_slot] = 1'b0;
            run_slot = NO_SLOT;
            run_done = 1'b0;
            kill = 1'b1;
            return;
        end
        for (int q = 2; q >= 0; q--) begin
            n = q_load(q);
            k = 0;
            hit = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!hit && slot_id[walk[i]] == jid) begin
                    hit = 1'b1;
                    slot_used[walk[i]] = 1'b0;
                end else begin
                    keep[k] = walk[i];
                    k++;
                end
            end
            if (hit) begin
                q_store(q, k);
                return;
            end
        end
        st = ST_NOT_FOUND;
    endfunction

    function automatic void end_of_slice();
        int lim;
        int nxt;
        if (slice_cnt >= -1 && slice_cnt < 255) slice_cnt++;
        if (!busy || slice_cnt <= 0) return;
        case (run_lvl)
            2'd3: lim = cfg_high;
            2'd2: lim = cfg_mid;
            2'd1: lim = cfg_low;
            default: return;
        endcase
        if (slice_cnt < lim) return;
        nxt = NO_SLOT;
        for (int q = 2; q >= 0 && nxt == NO_SLOT; q--) nxt = q_pop(q);
        switch_job(nxt);
        if (nxt == NO_SLOT && busy) slice_cnt = 0;
    endfunction

    function automatic t_sched_out schedule_step(logic [1:0] fn, logic [1:0] prio,
                                                 logic [15:0] jid);
        t_sched_out r;
        int lvl;
        r = '0;
        lvl = (prio == 2'd0) ? 1 : int'(prio);
        ev_started = 1'b0;
        ev_stopped = 1'b0;
        ev_stopped_job = '0;
        if (fn == FN_FIN) begin
            if (run_slot != NO_SLOT) run_done = 1'b1;
        end else begin
            age_waiting();
            if (fn == FN_ENQ) r.new_job_id = enqueue_job(lvl, r.status);
            else if (fn == FN_DEQ) dequeue_job(jid, r.killed, r.status);
            end_of_slice();
        end
        r.running_valid = (run_slot != NO_SLOT);
        r.running_job = (run_slot != NO_SLOT) ? slot_id[run_slot] : '0;
        r.running_level = run_lvl;
        r.started = ev_started;
        r.stopped_valid = ev_stopped;
        r.stopped_job = ev_stopped_job;
        return r;
    endfunction

    function automatic int used_slots();
        int c;
        c = 0;
        for (int i = 0; i < NSLOT; i++) c += slot_used[i];
        return c;
    endfunction

    // Picks a live job id where one exists, else a random one.
    function automatic logic [15:0] pick_live_id();
        int s;
        s = $urandom_range(NSLOT - 1);
        for (int i = 0; i < NSLOT; i++) begin
            if (slot_used[(s + i) % NSLOT]) return slot_id[(s + i) % NSLOT];
        end
        return 16'($urandom);
    endfunction

    task automatic send_item(logic [1:0] fn, logic [1:0] prio, logic [15:0] jid);
        i_valid <= 1'b1;
        i_func <= fn;
        i_priority_req <= prio;
        i_job_id <= jid;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(schedule_step(fn, prio, jid));
        if ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PROMOTE:    cfg_promote = val;
            REG_SLICE_HIGH: cfg_high = val;
            REG_SLICE_MID:  cfg_mid = val;
            default:        cfg_low = val;
        endcase
    endtask

    task automatic set_config(logic [7:0] pw, logic [7:0] hi, logic [7:0] md,
                              logic [7:0] lo);
        drain();
        write_reg(REG_PROMOTE, pw);
        write_reg(REG_SLICE_HIGH, hi);
        write_reg(REG_SLICE_MID, md);
        write_reg(REG_SLICE_LOW, lo);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_sched_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected result item %p", got);
            end else begin
                want = pending_results.pop_front();
                if (want !== got) begin
                    err_count++;
                    if (err_count <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    task automatic test_directed();
        send_item(FN_FIN, 2'd1, 16'd0);
        send_item(FN_ENQ, 2'd1, 16'd0);
        send_item(FN_ENQ, 2'd2, 16'hFFFF);
        send_item(FN_ENQ, 2'd3, 16'd0);
        send_item(FN_ENQ, 2'd0, 16'd0);
        send_item(FN_TICK, 2'd3, 16'd0);
        send_item(FN_FIN, 2'd3, 16'd0);
        send_item(FN_TICK, 2'd0, 16'd0);
        send_item(FN_DEQ, 2'd1, 16'hFFFF);
        send_item(FN_DEQ, 2'd1, 16'd0);
        send_item(FN_DEQ, 2'd1, (run_slot != NO_SLOT) ? slot_id[run_slot] : 16'd1);
        for (int i = 0; i < 14; i++) send_item(FN_ENQ, 2'(1 + i % 3), 16'd0);
        send_item(FN_DEQ, 2'd2, pick_live_id());
    endtask

    task automatic test_random(int count);
        logic [1:0] fn;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (used_slots() >= 15) fn = (r < 50) ? FN_DEQ : 2'($urandom);
            else if (r < 30) fn = FN_TICK;
            else if (r < 62) fn = FN_ENQ;
            else if (r < 82) fn = FN_DEQ;
            else fn = FN_FIN;
            send_item(fn, 2'($urandom),
                      (fn == FN_DEQ && $urandom_range(99) < 75) ? pick_live_id()
                                                                 : 16'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) slot_used[i] = 1'b0;
        for (int q = 0; q < 3; q++) q_head[q] = NO_SLOT;
        run_slot = NO_SLOT;
        run_done = 1'b0;
        run_lvl = '0;
        slice_cnt = -2;
        busy = 1'b0;
        id_ctr = '0;
        cfg_promote = PROMOTE_RST;
        cfg_high = SLICE_HIGH_RST;
        cfg_mid = SLICE_MID_RST;
        cfg_low = SLICE_LOW_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(150);
        set_config(8'd1, 8'd1, 8'd1, 8'd1);
        snd_idle_pct = 45;
        test_random(150);
        // Sender holds off until the scheduler has answered everything.
        drain();
        set_config(8'd255, 8'd255, 8'd255, 8'd255);
        snd_idle_pct = 0;
        rcv_stall_pct = 45;
        test_random(100);
        set_config(8'd0, 8'd0, 8'd0, 8'd0);
        snd_idle_pct = 21;
        rcv_stall_pct = 21;
        test_random(110);
        set_config(8'($urandom_range(2, 9)), 8'($urandom_range(1, 4)),
                   8'($urandom_range(1, 6)), 8'($urandom_range(2, 12)));
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        test_random(110);
        drain();

        if (err_count == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule
